FILE: hw/rtl/sialu_pkg.sv
package sialu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_LT  = 4'd5,
    OP_LE  = 4'd6,
    OP_GT  = 4'd7,
    OP_GE  = 4'd8,
    OP_EQ  = 4'd9,
    OP_NE  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HIGH    = 3'd1,
    ST_LOW     = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2,
    CLS_MOD  = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t    cls;
    logic    is_bool;
    status_t status;
    logic    neg_q;
    logic    neg_r;
  } ctl_t;

endpackage

FILE: hw/rtl/sialu_front.sv
module sialu_front #(
  parameter int DW  = 32,
  parameter int OPW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [3:0]         in_op,
  input  logic               in_kind,
  input  logic [31:0]        in_left,
  input  logic [31:0]        in_right,
  input  logic               dn_en,
  output logic               en_o,
  output logic               out_valid,
  output sialu_pkg::ctl_t    out_ctl,
  output logic [DW-1:0]      out_res,
  output logic [OPW-1:0]     out_a,
  output logic [OPW-1:0]     out_rem,
  output logic [OPW-1:0]     out_d
);
  import sialu_pkg::*;

  localparam int XW = 2 * OPW + 2;
  localparam logic signed [XW-1:0] VMAX = XW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [XW-1:0] VMIN = ~VMAX;

  function automatic logic [DW-1:0] sat_val(input logic signed [XW-1:0] x);
    logic [DW-1:0] y;
    if (x > VMAX) y = VMAX[DW-1:0];
    else if (x < VMIN) y = VMIN[DW-1:0];
    else y = x[DW-1:0];
    return y;
  endfunction

  function automatic status_t sat_st(input logic signed [XW-1:0] x);
    status_t s;
    if (x > VMAX) s = ST_HIGH;
    else if (x < VMIN) s = ST_LOW;
    else s = ST_OK;
    return s;
  endfunction

  // stage 1: operand capture
  logic                  v1_r;
  logic [3:0]            op1_r;
  logic                  kind1_r;
  logic signed [OPW-1:0] l1_r;
  logic signed [OPW-1:0] r1_r;

  // stage 2: execute
  logic           v2_r;
  ctl_t           ctl2_r, ctl2_nxt;
  logic [DW-1:0]  res2_r, res2_nxt;
  logic [OPW-1:0] a2_r, a2_nxt;
  logic [OPW-1:0] rem2_r, rem2_nxt;
  logic [OPW-1:0] d2_r, d2_nxt;

  // stage 3: multiply saturation
  logic           v3_r;
  ctl_t           ctl3_r, ctl3_nxt;
  logic [DW-1:0]  res3_r, res3_nxt;

  logic en1, en2, en3;

  logic signed [XW-1:0]    lx, rx, sum, dif, px;
  logic signed [2*OPW-1:0] prod;
  logic [OPW-1:0]          lmag, rmag;
  logic                    ba, bb;

  assign en3  = !v3_r || dn_en;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign en_o = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      op1_r   <= in_op;
      kind1_r <= in_kind;
      l1_r    <= in_left[OPW-1:0];
      r1_r    <= in_right[OPW-1:0];
    end
  end

  assign lx   = XW'(l1_r);
  assign rx   = XW'(r1_r);
  assign sum  = lx + rx;
  assign dif  = lx - rx;
  assign prod = l1_r * r1_r;
  assign lmag = l1_r[OPW-1] ? OPW'(-l1_r) : OPW'(l1_r);
  assign rmag = r1_r[OPW-1] ? OPW'(-r1_r) : OPW'(r1_r);
  assign ba   = l1_r[0];
  assign bb   = r1_r[0];

  always_comb begin
    ctl2_nxt.cls     = CLS_DONE;
    ctl2_nxt.is_bool = 1'b0;
    ctl2_nxt.status  = ST_OK;
    ctl2_nxt.neg_q   = l1_r[OPW-1] ^ r1_r[OPW-1];
    ctl2_nxt.neg_r   = l1_r[OPW-1];
    res2_nxt         = '0;
    a2_nxt           = lmag;
    rem2_nxt         = '0;
    d2_nxt           = rmag;
    if (kind1_r) begin
      unique case (op_t'(op1_r))
        OP_ADD: begin
          res2_nxt         = DW'(ba | bb);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_MUL: begin
          res2_nxt         = DW'(ba & bb);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_EQ: begin
          res2_nxt         = DW'(ba == bb);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_NE: begin
          res2_nxt         = DW'(ba != bb);
          ctl2_nxt.is_bool = 1'b1;
        end
        default: ctl2_nxt.status = ST_INVALID;
      endcase
    end else begin
      unique case (op_t'(op1_r))
        OP_ADD: begin
          res2_nxt        = sat_val(sum);
          ctl2_nxt.status = sat_st(sum);
        end
        OP_SUB: begin
          res2_nxt        = sat_val(dif);
          ctl2_nxt.status = sat_st(dif);
        end
        OP_MUL: begin
          ctl2_nxt.cls       = CLS_MUL;
          {rem2_nxt, a2_nxt} = prod;
        end
        OP_DIV, OP_MOD: begin
          if (r1_r == '0) begin
            res2_nxt        = VMAX[DW-1:0];
            ctl2_nxt.status = ST_DIVZERO;
          end else begin
            ctl2_nxt.cls = (op_t'(op1_r) == OP_DIV) ? CLS_DIV : CLS_MOD;
          end
        end
        OP_LT: begin
          res2_nxt         = DW'(l1_r < r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_LE: begin
          res2_nxt         = DW'(l1_r <= r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_GT: begin
          res2_nxt         = DW'(l1_r > r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_GE: begin
          res2_nxt         = DW'(l1_r >= r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_EQ: begin
          res2_nxt         = DW'(l1_r == r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        OP_NE: begin
          res2_nxt         = DW'(l1_r != r1_r);
          ctl2_nxt.is_bool = 1'b1;
        end
        default: ctl2_nxt.status = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      ctl2_r <= ctl2_nxt;
      res2_r <= res2_nxt;
      a2_r   <= a2_nxt;
      rem2_r <= rem2_nxt;
      d2_r   <= d2_nxt;
    end
  end

  assign px = XW'(signed'({rem2_r, a2_r}));

  always_comb begin
    ctl3_nxt = ctl2_r;
    res3_nxt = res2_r;
    if (ctl2_r.cls == CLS_MUL) begin
      ctl3_nxt.cls    = CLS_DONE;
      ctl3_nxt.status = sat_st(px);
      res3_nxt        = sat_val(px);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      ctl3_r  <= ctl3_nxt;
      res3_r  <= res3_nxt;
      out_a   <= a2_r;
      out_rem <= '0;
      out_d   <= d2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_ctl   = ctl3_r;
  assign out_res   = res3_r;

endmodule

FILE: hw/rtl/sialu_div_step.sv
module sialu_div_step #(
  parameter int DW  = 32,
  parameter int OPW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  sialu_pkg::ctl_t in_ctl,
  input  logic [DW-1:0]   in_res,
  input  logic [OPW-1:0]  in_a,
  input  logic [OPW-1:0]  in_rem,
  input  logic [OPW-1:0]  in_d,
  input  logic            dn_en,
  output logic            en_o,
  output logic            out_valid,
  output sialu_pkg::ctl_t out_ctl,
  output logic [DW-1:0]   out_res,
  output logic [OPW-1:0]  out_a,
  output logic [OPW-1:0]  out_rem,
  output logic [OPW-1:0]  out_d
);
  import sialu_pkg::*;

  logic           v_r;
  logic [OPW-1:0] rem_sh;
  logic [OPW:0]   trial;
  logic           fits;

  // one restoring step: shift in next dividend bit, subtract divisor if it fits
  assign rem_sh = {in_rem[OPW-2:0], in_a[OPW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, in_d};
  assign fits   = !trial[OPW] || in_rem[OPW-1];
  assign en_o   = !v_r || dn_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_o) begin
      v_r <= in_valid;
    end
    if (en_o) begin
      out_ctl <= in_ctl;
      out_res <= in_res;
      out_d   <= in_d;
      out_a   <= {in_a[OPW-2:0], fits};
      out_rem <= fits ? trial[OPW-1:0] : rem_sh;
    end
  end

  assign out_valid = v_r;

endmodule

FILE: hw/rtl/sialu_back.sv
module sialu_back #(
  parameter int DW  = 32,
  parameter int OPW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  sialu_pkg::ctl_t in_ctl,
  input  logic [DW-1:0]   in_res,
  input  logic [OPW-1:0]  in_a,
  input  logic [OPW-1:0]  in_rem,
  input  logic            out_stall,
  output logic            en_o,
  output logic            out_valid,
  output logic [31:0]     out_value,
  output logic            out_is_boolean,
  output logic [2:0]      out_status
);
  import sialu_pkg::*;

  localparam int XW = 2 * OPW + 2;
  localparam logic signed [XW-1:0] VMAX = XW'({1'b0, {(DW-1){1'b1}}});

  logic                 v_r;
  logic [DW-1:0]        res_r, res_nxt;
  status_t              st_r, st_nxt;
  logic                 isb_r;
  logic signed [XW-1:0] qx, rx;

  assign qx   = in_ctl.neg_q ? -XW'(signed'({1'b0, in_a})) : XW'(signed'({1'b0, in_a}));
  assign rx   = in_ctl.neg_r ? -XW'(signed'({1'b0, in_rem})) : XW'(signed'({1'b0, in_rem}));
  assign en_o = !v_r || !out_stall;

  // only the positive side can overflow: minimum divided by minus one
  always_comb begin
    res_nxt = in_res;
    st_nxt  = in_ctl.status;
    unique case (in_ctl.cls)
      CLS_DIV: begin
        if (qx > VMAX) begin
          res_nxt = VMAX[DW-1:0];
          st_nxt  = ST_HIGH;
        end else begin
          res_nxt = qx[DW-1:0];
        end
      end
      CLS_MOD: res_nxt = rx[DW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_o) begin
      v_r <= in_valid;
    end
    if (en_o) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
      isb_r <= in_ctl.is_bool;
    end
  end

  assign out_valid      = v_r;
  assign out_value      = 32'(signed'(res_r));
  assign out_is_boolean = isb_r;
  assign out_status     = st_r;

endmodule

FILE: hw/rtl/saturating_integer_alu_unit.sv
// Saturating integer ALU. One item per cycle sustained while out_stall is low;
// the pipeline depth is set by the radix-2 divider that spends one pipeline
// stage per quotient bit. Every operation travels the full pipeline so results
// leave in order. Stages hold their item under out_stall and empty stages still
// fill.
module saturating_integer_alu_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic        in_operand_kind,
  input  logic [31:0] in_left_operand,
  input  logic [31:0] in_right_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_is_boolean,
  output logic [2:0]  out_status
);
  import sialu_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int OPW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic           v   [OPW+1];
  ctl_t           ctl [OPW+1];
  logic [DW-1:0]  res [OPW+1];
  logic [OPW-1:0] a   [OPW+1];
  logic [OPW-1:0] rem [OPW+1];
  logic [OPW-1:0] d   [OPW+1];
  logic           en  [OPW+1];
  logic           front_en;

  sialu_front #(.DW(DW), .OPW(OPW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_kind   (in_operand_kind),
    .in_left   (in_left_operand),
    .in_right  (in_right_operand),
    .dn_en     (en[0]),
    .en_o      (front_en),
    .out_valid (v[0]),
    .out_ctl   (ctl[0]),
    .out_res   (res[0]),
    .out_a     (a[0]),
    .out_rem   (rem[0]),
    .out_d     (d[0])
  );

  for (genvar i = 0; i < OPW; i++) begin : g_div
    sialu_div_step #(.DW(DW), .OPW(OPW)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_ctl    (ctl[i]),
      .in_res    (res[i]),
      .in_a      (a[i]),
      .in_rem    (rem[i]),
      .in_d      (d[i]),
      .dn_en     (en[i+1]),
      .en_o      (en[i]),
      .out_valid (v[i+1]),
      .out_ctl   (ctl[i+1]),
      .out_res   (res[i+1]),
      .out_a     (a[i+1]),
      .out_rem   (rem[i+1]),
      .out_d     (d[i+1])
    );
  end

  sialu_back #(.DW(DW), .OPW(OPW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (v[OPW]),
    .in_ctl         (ctl[OPW]),
    .in_res         (res[OPW]),
    .in_a           (a[OPW]),
    .in_rem         (rem[OPW]),
    .out_stall      (out_stall),
    .en_o           (en[OPW]),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_is_boolean (out_is_boolean),
    .out_status     (out_status)
  );

  assign in_stall = !front_en;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import sialu_pkg::*;

  localparam int LATENCY = 36;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] value;
    logic        is_bool;
    logic [2:0]  status;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int errors;
    int checked;

    function alu_result_t compute(logic [3:0] op, logic kind, logic [31:0] a, logic [31:0] b);
      alu_result_t r;
      longint l, rr, s, p;
      logic ab, bb;
      r.value = '0;
      r.is_bool = 1'b0;
      r.status = ST_OK;
      if (kind) begin
        ab = a[0];
        bb = b[0];
        r.is_bool = 1'b1;
        case (op)
          OP_ADD: r.value = {31'd0, ab | bb};
          OP_MUL: r.value = {31'd0, ab & bb};
          OP_EQ: r.value = {31'd0, ab == bb};
          OP_NE: r.value = {31'd0, ab != bb};
          default: begin
            r.is_bool = 1'b0;
            r.status = ST_INVALID;
          end
        endcase
        return r;
      end
      l = longint'($signed(a));
      rr = longint'($signed(b));
      case (op)
        OP_ADD, OP_SUB, OP_MUL: begin
          if (op == OP_ADD) s = l + rr;
          else if (op == OP_SUB) s = l - rr;
          else s = l * rr;
          if (s > 64'sd2147483647) begin
            r.value = 32'h7fffffff;
            r.status = ST_HIGH;
          end else if (s < -64'sd2147483648) begin
            r.value = 32'h80000000;
            r.status = ST_LOW;
          end else r.value = s[31:0];
        end
        OP_DIV: begin
          if (rr == 0) begin
            r.value = 32'h7fffffff;
            r.status = ST_DIVZERO;
          end else begin
            p = l / rr;
            if (p > 64'sd2147483647) begin
              r.value = 32'h7fffffff;
              r.status = ST_HIGH;
            end else r.value = p[31:0];
          end
        end
        OP_MOD: begin
          if (rr == 0) begin
            r.value = 32'h7fffffff;
            r.status = ST_DIVZERO;
          end else begin
            p = l % rr;
            r.value = p[31:0];
          end
        end
        OP_LT: begin r.value = {31'd0, l < rr}; r.is_bool = 1'b1; end
        OP_LE: begin r.value = {31'd0, l <= rr}; r.is_bool = 1'b1; end
        OP_GT: begin r.value = {31'd0, l > rr}; r.is_bool = 1'b1; end
        OP_GE: begin r.value = {31'd0, l >= rr}; r.is_bool = 1'b1; end
        OP_EQ: begin r.value = {31'd0, l == rr}; r.is_bool = 1'b1; end
        OP_NE: begin r.value = {31'd0, l != rr}; r.is_bool = 1'b1; end
        default: r.status = ST_INVALID;
      endcase
      return r;
    endfunction

    function void note_item(logic [3:0] op, logic kind, logic [31:0] a, logic [31:0] b);
      pending.push_back(compute(op, kind, a, b));
    endfunction

    task automatic check_result(logic [31:0] v, logic isb, logic [2:0] st);
      alu_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h", v));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (v !== e.value || isb !== e.is_bool || st !== e.status)
        report_mismatch($sformatf("got %h/%b/%0d want %h/%b/%0d",
                                  v, isb, st, e.value, e.is_bool, e.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_op = '0;
  logic        in_operand_kind = 1'b0;
  logic [31:0] in_left_operand = '0;
  logic [31:0] in_right_operand = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic        out_is_boolean;
  logic [2:0]  out_status;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int sent = 0;
  int mismatches = 0;
  longint cycle = 0;
  alu_scoreboard sb;

  saturating_integer_alu_unit #(.DATA_WIDTH(32)) i_dut (.*);

  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item(in_op, in_operand_kind, in_left_operand, in_right_operand);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_is_boolean, out_status);
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'h0;
      4: return $urandom_range(20) - 10;
      5: return 32'h1 << $urandom_range(31);
      6: return $urandom_range(65535) - 32768;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic [3:0] op, logic kind, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_operand_kind <= kind;
    in_left_operand <= a;
    in_right_operand <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    logic [3:0] op;
    repeat (n) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      send_item(op, $urandom_range(3) == 0, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_ADD, 0, 32'h7fffffff, 32'h1);
    send_item(OP_ADD, 0, 32'h80000000, 32'hffffffff);
    send_item(OP_SUB, 0, 32'h80000000, 32'h1);
    send_item(OP_SUB, 0, 32'h7fffffff, 32'hffffffff);
    send_item(OP_MUL, 0, 32'h80000000, 32'hffffffff);
    send_item(OP_MUL, 0, 32'h80000000, 32'h1);
    send_item(OP_MUL, 0, 32'h10000, 32'hffff0000);
    send_item(OP_MUL, 0, 32'h0, 32'h80000000);
    send_item(OP_DIV, 0, 32'h80000000, 32'hffffffff);
    send_item(OP_DIV, 0, 32'h5, 32'h0);
    send_item(OP_DIV, 0, 32'hfffffff9, 32'h2);
    send_item(OP_MOD, 0, 32'h80000000, 32'hffffffff);
    send_item(OP_MOD, 0, 32'h5, 32'h0);
    send_item(OP_MOD, 0, 32'hfffffff9, 32'h2);
    send_item(OP_LT, 0, 32'h80000000, 32'h7fffffff);
    send_item(OP_LE, 0, 32'h3, 32'h3);
    send_item(OP_GT, 0, 32'h7fffffff, 32'h80000000);
    send_item(OP_GE, 0, 32'h2, 32'h3);
    send_item(OP_EQ, 0, 32'hffffffff, 32'hffffffff);
    send_item(OP_NE, 0, 32'h1, 32'h2);
    send_item(OP_ADD, 1, 32'hfffffffe, 32'h1);
    send_item(OP_MUL, 1, 32'hffffffff, 32'h3);
    send_item(OP_EQ, 1, 32'h2, 32'h0);
    send_item(OP_SUB, 1, 32'h1, 32'h1);
    send_item(4'd15, 0, 32'h1, 32'h1);
    in_valid <= 1'b0;
    wait_drained();

    send_idle_pct = 36;
    recv_idle_pct = 74;
    send_random(500);
    send_idle_pct = 74;
    recv_idle_pct = 36;
    send_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 200;
    send_random(300);
    wait_drained();
    send_random(375);

    wait_drained();
    repeat (LATENCY + 4) @(negedge clk);
    $display("sent %0d items, checked %0d results over all ops, kinds and saturation cases",
             sent, sb.checked);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
